/* design/bmt_pkg.sv */
// Shared types and constants for the byte to multibyte translator.
package bmt_pkg;

	// Requested output slots per table entry; only four fit in one entry.
	localparam int SLOTS_PER_ENTRY = 4;
	localparam int SLOT_W          = 8;
	localparam int ENTRY_W         = 32;
	localparam int MAX_SLOTS       = ENTRY_W / SLOT_W;
	localparam int ACTIVE_SLOTS    = (SLOTS_PER_ENTRY < MAX_SLOTS) ? SLOTS_PER_ENTRY : MAX_SLOTS;
	localparam int STORE_DEPTH     = 256;
	localparam int IDX_W           = $clog2(STORE_DEPTH);

	// Bits of an entry that belong to active slots.
	localparam logic [ENTRY_W-1:0] ACTIVE_MASK =
		ENTRY_W'((64'(1) << (SLOT_W * ACTIVE_SLOTS)) - 64'(1));

	// Queue between the front and the back part.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Input mode codes.
	localparam logic MODE_TRANSLATE = 1'b0;
	localparam logic MODE_LOAD      = 1'b1;

	// Byte that terminates a string and is never translated.
	localparam logic [SLOT_W-1:0] TERMINATOR = '0;

	typedef logic [ENTRY_W-1:0] entry_t;

	// Occupancy flags of the queue.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* design/bmt_front.sv */
// Front part: accepts beats, keeps the translation table and classifies each beat.
module bmt_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     mode,
	input  logic [bmt_pkg::SLOT_W-1:0]  byte_in,
	input  logic [bmt_pkg::ENTRY_W-1:0] entry_word,
	input  bmt_pkg::q_status_t       q_status,
	output logic                     push,
	output bmt_pkg::entry_t          push_entry
);
	import bmt_pkg::*;

	logic [ENTRY_W-1:0] mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] written_q;

	logic             valid_s1;
	logic             xlate_s1;
	logic             written_s1;
	logic [IDX_W-1:0] idx_s1;
	entry_t           rd_data_s1;

	entry_t word_s1;
	logic   want_push;
	logic   hold;
	logic   accept;

	assign accept = in_valid && !in_stall;

	// Table memory: one write for a load beat, one registered read per beat.
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_LOAD) begin
			mem[byte_in] <= entry_word & ACTIVE_MASK;
		end
		if (accept) begin
			rd_data_s1 <= mem[byte_in];
		end
	end

	// Written flags: an entry never loaded since reset reads as the identity map.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (accept && mode == MODE_LOAD) begin
			written_q[byte_in] <= 1'b1;
		end
	end

	// Classification stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xlate_s1   <= (mode == MODE_TRANSLATE) && (byte_in != TERMINATOR);
			written_s1 <= written_q[byte_in];
			idx_s1     <= byte_in;
		end
	end

	// Only a translate beat whose entry has a non-zero slot goes to the back part.
	always_comb begin
		word_s1    = written_s1 ? rd_data_s1 : (ENTRY_W'(idx_s1) & ACTIVE_MASK);
		want_push  = valid_s1 && xlate_s1 && (word_s1 != '0);
		hold       = want_push && q_status.full;
		in_stall   = hold;
		push       = want_push && !q_status.full;
		push_entry = word_s1;
	end

endmodule

/* design/bmt_queue.sv */
// Short queue of table entries between the front and the back part.
module bmt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bmt_pkg::entry_t    push_entry,
	input  logic               pop,
	output bmt_pkg::entry_t    head,
	output bmt_pkg::q_status_t q_status
);
	import bmt_pkg::*;

	entry_t            slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= QCNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= QCNT_W'(count_q - 1'b1);
			end
		end
	end

	assign head           = slots_q[rd_ptr_q];
	assign q_status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);

	// The front part never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("push into full queue");

	// The fill count stays within the depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

/* design/bmt_back.sv */
// Back part: sends the non-zero slots of each entry, one beat per cycle while the output is not stalled.
module bmt_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bmt_pkg::entry_t         head,
	input  bmt_pkg::q_status_t      q_status,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [bmt_pkg::SLOT_W-1:0] out_byte,
	output logic                    last_of_item
);
	import bmt_pkg::*;

	entry_t            rem_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] out_byte_q;
	logic              last_q;

	logic              adv;
	logic              have;
	entry_t            src;
	entry_t            cleared;
	logic [SLOT_W-1:0] sel_byte;
	logic              found;

	// Work from the rest of the current entry, else from the head of the queue.
	always_comb begin
		adv  = !out_valid_q || !out_stall;
		have = (rem_q != '0) || !q_status.empty;
		src  = (rem_q != '0) ? rem_q : head;
		pop  = adv && (rem_q == '0) && !q_status.empty;
	end

	// Pick the lowest non-zero slot and clear it.
	always_comb begin
		found    = 1'b0;
		sel_byte = '0;
		cleared  = src;
		for (int s = 0; s < ACTIVE_SLOTS; s++) begin
			if (!found && src[s*SLOT_W +: SLOT_W] != '0) begin
				found                        = 1'b1;
				sel_byte                     = src[s*SLOT_W +: SLOT_W];
				cleared[s*SLOT_W +: SLOT_W]  = '0;
			end
		end
	end

	// Output register and the remaining slots of the entry in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (adv) begin
			out_valid_q <= have;
			if (have) begin
				rem_q <= cleared;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && have) begin
			out_byte_q <= sel_byte;
			last_q     <= (cleared == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_item = last_q;

	// A sent byte is never zero.
	a_nonzero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_byte_q != '0))
		else $error("zero byte on output");

	// Slots still pending mean the beat in the output register was not the last.
	a_rem_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != '0) |-> (out_valid_q && !last_q))
		else $error("pending slots after last beat");

	// The queue is only read when it holds an entry.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");

endmodule

/* design/byte_to_multibyte_translator.sv */
// Path: a beat that yields output passes the stage register, the entry queue and the output
// register. Throughput: one input beat per cycle unless stalled; an entry's non-zero slots leave
// one per output beat, so expanding bytes stall the input once the four-entry queue fills.
// Reset: asynchronous, active low; the table reads as the identity map at once, with no
// clearing pass, since per-entry written flags are cleared.
// Top level: front part with table, entry queue, back part serialising slots.
module byte_to_multibyte_translator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [bmt_pkg::SLOT_W-1:0]  byte_in,
	input  logic [bmt_pkg::ENTRY_W-1:0] entry_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bmt_pkg::SLOT_W-1:0]  out_byte,
	output logic                        last_of_item
);
	import bmt_pkg::*;

	logic      push;
	entry_t    push_entry;
	logic      pop;
	entry_t    head;
	q_status_t q_status;

	// Accepts beats, loads the table and looks up entries.
	bmt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.byte_in    (byte_in),
		.entry_word (entry_word),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouples lookup from serialisation.
	bmt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	// Sends the non-zero slots in order and marks the last.
	bmt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_of_item (last_of_item)
	);

endmodule

/* tb/bmt_checker.sv */
// Watches both channels of the byte to multibyte translator, predicts its output and compares.
`timescale 1ns / 1ps

module bmt_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        mode,
	input  logic [bmt_pkg::SLOT_W-1:0]  byte_in,
	input  logic [bmt_pkg::ENTRY_W-1:0] entry_word,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [bmt_pkg::SLOT_W-1:0]  out_byte,
	input  logic                        last_of_item,
	output int                          fail_count,
	output int                          expected_left
);
	import bmt_pkg::*;

	// One predicted output beat.
	typedef struct packed {
		logic [SLOT_W-1:0] code;
		logic              last;
	} out_beat_t;

	// Our own copy of the translation table and the bytes still owed by the block.
	entry_t    xlat_table [STORE_DEPTH];
	out_beat_t pending_bytes [$];
	int        errs;

	// Queue one output beat per non-zero active slot, marking the final one.
	task automatic queue_slots(input entry_t word);
		int        last_slot;
		out_beat_t beat;
		last_slot = -1;
		for (int s = 0; s < ACTIVE_SLOTS; s++)
			if (word[s*SLOT_W +: SLOT_W] != '0)
				last_slot = s;
		for (int s = 0; s <= last_slot; s++) begin
			if (word[s*SLOT_W +: SLOT_W] != '0) begin
				beat.code = word[s*SLOT_W +: SLOT_W];
				beat.last = (s == last_slot);
				pending_bytes.push_back(beat);
			end
		end
	endtask

	// Compare accepted output beats first; a beat accepted on the input at the same edge
	// cannot produce output before later edges.
	always @(posedge clk or negedge arst_n) begin : predict_and_compare
		out_beat_t want;
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++)
				xlat_table[i] = entry_t'(i) & ACTIVE_MASK;
			pending_bytes.delete();
			errs = 0;
			fail_count <= 0;
			expected_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_bytes.size() == 0) begin
					errs++;
					$display("%0t: unexpected output beat, expected none, got byte %02h last %0b",
						$time, out_byte, last_of_item);
				end else begin
					want = pending_bytes.pop_front();
					if (out_byte !== want.code) begin
						errs++;
						$display("%0t: out_byte expected %02h, got %02h",
							$time, want.code, out_byte);
					end
					if (last_of_item !== want.last) begin
						errs++;
						$display("%0t: last_of_item expected %0b, got %0b",
							$time, want.last, last_of_item);
					end
				end
			end

			// A load rewrites one entry; a translation expands the entry unless it is the
			// terminator byte.
			if (in_valid && !in_stall) begin
				if (mode == MODE_LOAD)
					xlat_table[byte_in] = entry_word & ACTIVE_MASK;
				else if (byte_in != TERMINATOR)
					queue_slots(xlat_table[byte_in]);
			end

			fail_count <= errs;
			expected_left <= pending_bytes.size();
		end
	end

endmodule

/* tb/tb_byte_to_multibyte_translator.sv */
// Top of the translator testbench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module tb_byte_to_multibyte_translator;
	import bmt_pkg::*;

	localparam int RAND_ITEMS   = 220;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 200000;
	localparam logic [SLOT_W-1:0] POOL_BASE = 8'h20;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                mode;
	logic [SLOT_W-1:0]   byte_in;
	logic [ENTRY_W-1:0]  entry_word;
	logic                out_valid;
	logic                out_stall;
	logic [SLOT_W-1:0]   out_byte;
	logic                last_of_item;
	int                  fail_count;
	int                  expected_left;
	logic                hold_req = 1'b0;
	int                  cycle_count = 0;

	// 8 ns clock.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	byte_to_multibyte_translator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.byte_in      (byte_in),
		.entry_word   (entry_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_of_item (last_of_item)
	);

	bmt_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.byte_in       (byte_in),
		.entry_word    (entry_word),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.last_of_item  (last_of_item),
		.fail_count    (fail_count),
		.expected_left (expected_left)
	);

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_byte_to_multibyte_translator: FAIL");
			$finish;
		end
	end

	// Offer one input beat and hold it until the block takes it.
	task automatic put_beat(input logic m, input logic [SLOT_W-1:0] b,
			input logic [ENTRY_W-1:0] w);
		in_valid   <= 1'b1;
		mode       <= m;
		byte_in    <= b;
		entry_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Build an entry slot by slot, so that zero slots, full bytes and gaps all turn up.
	function automatic logic [ENTRY_W-1:0] make_entry_word();
		logic [ENTRY_W-1:0] w;
		int                 pick;
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		w = '0;
		for (int s = 0; s < ENTRY_W / SLOT_W; s++) begin
			pick = $urandom_range(0, 7);
			if (pick < 2)
				w[s*SLOT_W +: SLOT_W] = '0;
			else if (pick == 2)
				w[s*SLOT_W +: SLOT_W] = '1;
			else
				w[s*SLOT_W +: SLOT_W] = SLOT_W'($urandom_range(1, 255));
		end
		return w;
	endfunction

	// Random beat: mostly translations, with loads and translations aimed at a small pool of
	// indices so that rewritten entries are read back often.
	task automatic random_beat();
		logic [SLOT_W-1:0] idx;
		if ($urandom_range(0, 1) == 0)
			idx = POOL_BASE + SLOT_W'($urandom_range(0, 15));
		else
			idx = SLOT_W'($urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0)
			put_beat(MODE_LOAD, idx, make_entry_word());
		else
			put_beat(MODE_TRANSLATE, idx, $urandom);
	endtask

	// Receiver: stall segments of random length and kind, plus one long hold-off on request.
	initial begin : receiver
		int   seg_left;
		int   seg_kind;
		int   hold_left;
		int   tick;
		logic hold_done;
		seg_left  = 0;
		seg_kind  = 0;
		hold_left = 0;
		tick      = 0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(1, 40);
					seg_kind = $urandom_range(0, 3);
				end
				seg_left--;
				tick++;
				case (seg_kind)
					0: out_stall <= 1'b0;
					1: out_stall <= 1'($urandom_range(0, 1));
					2: out_stall <= ($urandom_range(0, 4) != 0);
					default: out_stall <= (tick % 3 == 0);
				endcase
			end
			@(posedge clk);
		end
	end

	// Sender: reset, directed beats, then random bursts, then drain and verdict.
	initial begin : sender
		int sent;
		int burst;
		sent       = 0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = MODE_TRANSLATE;
		byte_in    = '0;
		entry_word = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Identity entries after reset, including the terminator byte.
		put_beat(MODE_TRANSLATE, 8'h00, 32'h0000_0000);
		put_beat(MODE_TRANSLATE, 8'h01, 32'hFFFF_FFFF);
		put_beat(MODE_TRANSLATE, 8'hFF, 32'h0000_0000);
		put_beat(MODE_TRANSLATE, 8'h80, 32'h0000_0000);
		// All four slots in use.
		put_beat(MODE_LOAD,      8'h41, 32'hFFFE_FDFC);
		put_beat(MODE_TRANSLATE, 8'h41, 32'h0000_0000);
		// Empty entry gives nothing.
		put_beat(MODE_LOAD,      8'h42, 32'h0000_0000);
		put_beat(MODE_TRANSLATE, 8'h42, 32'h0000_0000);
		// Zero slots inside an entry are skipped.
		put_beat(MODE_LOAD,      8'h43, 32'h00AB_00CD);
		put_beat(MODE_TRANSLATE, 8'h43, 32'h0000_0000);
		put_beat(MODE_LOAD,      8'h44, 32'h7F00_0000);
		put_beat(MODE_TRANSLATE, 8'h44, 32'h0000_0000);
		// Entry zero may be loaded but the terminator still gives nothing.
		put_beat(MODE_LOAD,      8'h00, 32'h1122_3344);
		put_beat(MODE_TRANSLATE, 8'h00, 32'h0000_0000);
		put_beat(MODE_LOAD,      8'hFF, 32'hFFFF_FFFF);
		put_beat(MODE_TRANSLATE, 8'hFF, 32'h0000_0000);
		put_beat(MODE_LOAD,      8'h80, 32'h0101_0101);
		put_beat(MODE_TRANSLATE, 8'h80, 32'h0000_0000);
		// The word is ignored on a translation.
		put_beat(MODE_TRANSLATE, 8'h41, 32'hFFFF_FFFF);
		put_beat(MODE_TRANSLATE, 8'h42, 32'hFFFF_FFFF);
		put_beat(MODE_TRANSLATE, 8'h7F, 32'h0000_0000);
		put_beat(MODE_LOAD,      8'h55, 32'h0000_00AA);
		put_beat(MODE_TRANSLATE, 8'h55, 32'h0000_0000);
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);

		// The first burst runs without gaps against the long hold-off, filling the block.
		while (sent < RAND_ITEMS) begin
			if (sent == 0) begin
				hold_req = 1'b1;
				burst = 24;
			end else begin
				burst = $urandom_range(1, 16);
			end
			repeat (burst) begin
				random_beat();
				sent++;
			end
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		// The expectation count is registered, so step the clock before watching it.
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_byte_to_multibyte_translator: PASS");
		else
			$display("tb_byte_to_multibyte_translator: FAIL");
		$finish;
	end

endmodule
